[rtl/epoch_to_calendar_datetime_defines.svh]
// ---------------------------------------------------------------------------
// epoch_to_calendar_datetime_defines.svh
// Assertion macros shared by the checking code of the calendar converter.
// ---------------------------------------------------------------------------
`ifndef EPOCH_TO_CALENDAR_DATETIME_DEFINES_SVH
`define EPOCH_TO_CALENDAR_DATETIME_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ECTD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ectd same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ECTD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ectd next-cycle check failed");

`endif

[rtl/ectd_pkg.sv]
// ---------------------------------------------------------------------------
// ectd_pkg
// Types, constants and the microcode table of the epoch to calendar converter.
// ---------------------------------------------------------------------------
package ectd_pkg;

    localparam logic [11:0] BASE_YEAR    = 12'd1970;
    localparam logic [6:0]  BASE_MOD100  = 7'd70;
    localparam logic [8:0]  BASE_MOD400  = 9'd370;
    localparam logic [6:0]  LAST_MOD100  = 7'd99;
    localparam logic [8:0]  LAST_MOD400  = 9'd399;
    localparam logic [8:0]  DAYS_LEAP    = 9'd366;
    localparam logic [8:0]  DAYS_COMMON  = 9'd365;
    localparam logic [3:0]  MONTH_JAN    = 4'd1;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;

    // Scaled reciprocals, rounded up: 86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2.
    // Each is exact for the range of its pre-shifted dividend.
    localparam logic [25:0] RECIP_DAY  = 26'd50903317;   // 2^35 / 675
    localparam logic [25:0] RECIP_HOUR = 26'd9321;       // 2^21 / 225
    localparam logic [25:0] RECIP_MIN  = 26'd1093;       // 2^14 / 15

    // Steps per division: quotient first, remainder on the second step.
    localparam logic [4:0] DIV_STEPS = 5'd2;

    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_DIV,
        OP_LD_HOUR,
        OP_LD_MIN,
        OP_SAVE_MS,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        DS_DAY,
        DS_HOUR,
        DS_MIN
    } t_dsel;

    typedef enum logic [3:0] {
        ST_WAIT,
        ST_DIV_DAY,
        ST_LD_HOUR,
        ST_DIV_HOUR,
        ST_LD_MIN,
        ST_DIV_MIN,
        ST_SAVE_MS,
        ST_YEAR,
        ST_MONTH,
        ST_EMIT
    } t_step;

    typedef struct packed {
        t_op         op;
        t_dsel       dsel;
        logic [4:0]  cnt;
        t_step       nxt;
    } t_uword;

    typedef struct packed {
        logic        load;
        logic        step;
        t_dsel       sel;
    } t_div_ctl;

    // Microcode program: one control word per step.
    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        w = '{op: OP_WAIT, dsel: DS_DAY, cnt: 5'd0, nxt: ST_WAIT};
        unique case (pc)
            ST_WAIT:     w = '{op: OP_WAIT,    dsel: DS_DAY,  cnt: DIV_STEPS, nxt: ST_DIV_DAY};
            ST_DIV_DAY:  w = '{op: OP_DIV,     dsel: DS_DAY,  cnt: 5'd0,      nxt: ST_LD_HOUR};
            ST_LD_HOUR:  w = '{op: OP_LD_HOUR, dsel: DS_HOUR, cnt: DIV_STEPS, nxt: ST_DIV_HOUR};
            ST_DIV_HOUR: w = '{op: OP_DIV,     dsel: DS_HOUR, cnt: 5'd0,      nxt: ST_LD_MIN};
            ST_LD_MIN:   w = '{op: OP_LD_MIN,  dsel: DS_MIN,  cnt: DIV_STEPS, nxt: ST_DIV_MIN};
            ST_DIV_MIN:  w = '{op: OP_DIV,     dsel: DS_MIN,  cnt: 5'd0,      nxt: ST_SAVE_MS};
            ST_SAVE_MS:  w = '{op: OP_SAVE_MS, dsel: DS_MIN,  cnt: 5'd0,      nxt: ST_YEAR};
            ST_YEAR:     w = '{op: OP_YEAR,    dsel: DS_DAY,  cnt: 5'd0,      nxt: ST_MONTH};
            ST_MONTH:    w = '{op: OP_MONTH,   dsel: DS_DAY,  cnt: 5'd0,      nxt: ST_EMIT};
            ST_EMIT:     w = '{op: OP_EMIT,    dsel: DS_DAY,  cnt: 5'd0,      nxt: ST_WAIT};
            default:     w = '{op: OP_WAIT,    dsel: DS_DAY,  cnt: 5'd0,      nxt: ST_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [16:0] divisor_of(input t_dsel sel);
        logic [16:0] d;
        d = SECS_PER_DAY;
        unique case (sel)
            DS_DAY:  d = SECS_PER_DAY;
            DS_HOUR: d = SECS_PER_HOUR;
            DS_MIN:  d = SECS_PER_MIN;
            default: d = SECS_PER_DAY;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [3:0] idx;
        logic [4:0] len;
        idx = month - MONTH_JAN;
        len = MONTH_DAYS[idx];
        if ((month == MONTH_FEB) && leap) begin
            len = len + 5'd1;
        end
        return len;
    endfunction

endpackage

[rtl/ectd_div.sv]
// ---------------------------------------------------------------------------
// ectd_div
// Divider by the day, hour and minute lengths through scaled reciprocals.
// ---------------------------------------------------------------------------
module ectd_div (
    input  logic               i_clk,
    input  ectd_pkg::t_div_ctl i_ctl,
    input  logic [31:0]        i_load_num,
    output logic [16:0]        o_rem,
    output logic [15:0]        o_quo
);
    import ectd_pkg::*;

    logic [31:0] r_num, n_num;
    logic [15:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [24:0] mul_x;
    logic [25:0] mul_m;
    logic [50:0] mul_p;
    logic [15:0] quo_est;
    logic [32:0] back;
    logic [32:0] diff;

    // Pre-shift the dividend and multiply by the reciprocal of the odd factor
    always_comb begin
        mul_x = r_num[31:7];
        mul_m = RECIP_DAY;
        unique case (i_ctl.sel)
            DS_DAY: begin
                mul_x = r_num[31:7];
                mul_m = RECIP_DAY;
            end
            DS_HOUR: begin
                mul_x = {12'd0, r_num[16:4]};
                mul_m = RECIP_HOUR;
            end
            DS_MIN: begin
                mul_x = {15'd0, r_num[11:2]};
                mul_m = RECIP_MIN;
            end
            default: begin
                mul_x = r_num[31:7];
                mul_m = RECIP_DAY;
            end
        endcase
        mul_p   = {26'd0, mul_x} * {25'd0, mul_m};
        quo_est = mul_p[50:35];
        unique case (i_ctl.sel)
            DS_DAY:  quo_est = mul_p[50:35];
            DS_HOUR: quo_est = {10'd0, mul_p[26:21]};
            DS_MIN:  quo_est = {9'd0, mul_p[20:14]};
            default: quo_est = mul_p[50:35];
        endcase
    end

    // Take the remainder from the quotient held since the previous step
    always_comb begin
        back  = {16'd0, r_quo} * {16'd0, divisor_of(i_ctl.sel)};
        diff  = {1'b0, r_num} - back;
        n_num = r_num;
        n_quo = r_quo;
        n_rem = r_rem;
        if (i_ctl.load) begin
            n_num = i_load_num;
        end else if (i_ctl.step) begin
            n_quo = quo_est;
            n_rem = diff[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

[rtl/epoch_to_calendar_datetime.sv]
// ---------------------------------------------------------------------------
// epoch_to_calendar_datetime
// Converts a 32-bit Unix seconds count to Gregorian date and time of day.
// ---------------------------------------------------------------------------
//  channel | handshake          | word
//  --------+--------------------+-----------------------------------------
//  input   | i_valid / o_ready  | i_epoch_seconds
//  output  | o_valid / i_ready  | o_year o_month o_day o_hour o_minute o_second
//
// From accept to result a word takes one year step per year past 1970 and one
// month step per month past January; one wait step follows.
// The year loop, one year per cycle, does most of the work; each of the three constant
// divisions runs as a quotient step and a remainder step of reciprocal multiplication in ectd_div.
// Synchronous active-low reset empties the output register and restarts the program.
// A stalled result holds; one more word is taken and then waits in the emit step.
// ---------------------------------------------------------------------------
module epoch_to_calendar_datetime (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);
    import ectd_pkg::*;

    t_step       r_pc, n_pc;
    t_uword      uw;
    logic [4:0]  r_cnt;
    logic [15:0] r_days;
    logic [11:0] r_year;
    logic [6:0]  r_y100;
    logic [8:0]  r_y400;
    logic [3:0]  r_month;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;

    logic        r_ovalid;
    logic [11:0] r_oyear;
    logic [3:0]  r_omonth;
    logic [4:0]  r_oday;
    logic [4:0]  r_ohour;
    logic [5:0]  r_ominute;
    logic [5:0]  r_osecond;

    t_div_ctl    div_ctl;
    logic [31:0] div_load_num;
    logic [16:0] div_rem;
    logic [15:0] div_quo;

    logic        accept;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        year_done;
    logic        month_done;
    logic        out_free;

    assign uw = ucode(r_pc);

    // Decode status used by jumps and datapath
    always_comb begin
        accept     = (uw.op == OP_WAIT) && i_valid;
        leap       = (r_year[1:0] == 2'd0) && ((r_y100 != 7'd0) || (r_y400 == 9'd0));
        ylen       = leap ? DAYS_LEAP : DAYS_COMMON;
        mlen       = month_len(r_month, leap);
        year_done  = (r_days < {7'd0, ylen});
        month_done = (r_month == MONTH_DEC) || (r_days < {11'd0, mlen});
        out_free   = !r_ovalid || i_ready;
    end

    // Next step: conditional jumps stay on the current step
    always_comb begin
        n_pc = r_pc;
        unique case (uw.op)
            OP_WAIT:  n_pc = accept ? uw.nxt : r_pc;
            OP_DIV:   n_pc = (r_cnt == 5'd1) ? uw.nxt : r_pc;
            OP_YEAR:  n_pc = year_done ? uw.nxt : r_pc;
            OP_MONTH: n_pc = month_done ? uw.nxt : r_pc;
            OP_EMIT:  n_pc = out_free ? uw.nxt : r_pc;
            default:  n_pc = uw.nxt;
        endcase
    end

    // Divider control from the control word
    always_comb begin
        div_ctl.load = 1'b0;
        div_ctl.step = 1'b0;
        div_ctl.sel  = uw.dsel;
        div_load_num = i_epoch_seconds;
        unique case (uw.op)
            OP_WAIT: begin
                div_ctl.load = accept;
            end
            OP_DIV: begin
                div_ctl.step = 1'b1;
            end
            OP_LD_HOUR: begin
                div_ctl.load = 1'b1;
                div_load_num = {15'd0, div_rem};
            end
            OP_LD_MIN: begin
                div_ctl.load = 1'b1;
                div_load_num = {15'd0, div_rem};
            end
            default: begin
                div_ctl.load = 1'b0;
            end
        endcase
    end

    ectd_div u_div (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_load_num (div_load_num),
        .o_rem      (div_rem),
        .o_quo      (div_quo)
    );

    // Sequencer and loop counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= ST_WAIT;
            r_cnt <= 5'd0;
        end else begin
            r_pc <= n_pc;
            if (div_ctl.load) begin
                r_cnt <= uw.cnt;
            end else if (div_ctl.step) begin
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    // Calendar datapath
    always_ff @(posedge i_clk) begin
        case (uw.op)
            OP_WAIT: begin
                if (accept) begin
                    r_year  <= BASE_YEAR;
                    r_y100  <= BASE_MOD100;
                    r_y400  <= BASE_MOD400;
                    r_month <= MONTH_JAN;
                end
            end
            OP_LD_HOUR: r_days <= div_quo;
            OP_LD_MIN:  r_hour <= div_quo[4:0];
            OP_SAVE_MS: begin
                r_minute <= div_quo[5:0];
                r_second <= div_rem[5:0];
            end
            OP_YEAR: begin
                if (!year_done) begin
                    r_days <= r_days - {7'd0, ylen};
                    r_year <= r_year + 12'd1;
                    r_y100 <= (r_y100 == LAST_MOD100) ? 7'd0 : r_y100 + 7'd1;
                    r_y400 <= (r_y400 == LAST_MOD400) ? 9'd0 : r_y400 + 9'd1;
                end
            end
            OP_MONTH: begin
                if (!month_done) begin
                    r_days  <= r_days - {11'd0, mlen};
                    r_month <= r_month + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: load on emit, drop valid when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((uw.op == OP_EMIT) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((uw.op == OP_EMIT) && out_free) begin
            r_oyear   <= r_year;
            r_omonth  <= r_month;
            r_oday    <= r_days[4:0] + 5'd1;
            r_ohour   <= r_hour;
            r_ominute <= r_minute;
            r_osecond <= r_second;
        end
    end

    assign o_ready  = (uw.op == OP_WAIT);
    assign o_valid  = r_ovalid;
    assign o_year   = r_oyear;
    assign o_month  = r_omonth;
    assign o_day    = r_oday;
    assign o_hour   = r_ohour;
    assign o_minute = r_ominute;
    assign o_second = r_osecond;

endmodule

[rtl/ectd_checker.sv]
// ---------------------------------------------------------------------------
// ectd_checker
// Port-level checks of the epoch to calendar converter, bound to the top.
// ---------------------------------------------------------------------------
`include "epoch_to_calendar_datetime_defines.svh"

module ectd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [31:0] i_epoch_seconds,
    input logic        o_valid,
    input logic        i_ready,
    input logic [11:0] o_year,
    input logic [3:0]  o_month,
    input logic [4:0]  o_day,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic [5:0]  o_second
);

    // Hold valid and the date and second fields of a stalled result word
    `ECTD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_year) && $stable(o_month) && $stable(o_day) && $stable(o_second))

    // One word at a time: ready drops after an accept
    `ECTD_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // Date fields stay in calendar range
    `ECTD_ASSERT_IMP(a_date_range, i_clk, i_rst_n, o_valid, o_year >= 12'd1970 && o_year <= 12'd2106 && o_month >= 4'd1 && o_month <= 4'd12 && o_day >= 5'd1)

    // Time fields stay in clock range
    `ECTD_ASSERT_IMP(a_time_range, i_clk, i_rst_n, o_valid, o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59)

endmodule

bind epoch_to_calendar_datetime ectd_checker u_ectd_checker (.*);
